[hw/rtl/ps2sc_pkg.sv]
`default_nettype none

package ps2sc_pkg;

	localparam int ROM_DEPTH = 96;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [6:0] MAX_CODE    = 7'h5F;

	localparam logic [6:0] K_CTRL    = 7'h1D;
	localparam logic [6:0] K_SHIFT_L = 7'h2A;
	localparam logic [6:0] K_SLASH   = 7'h35;
	localparam logic [6:0] K_SHIFT_R = 7'h36;
	localparam logic [6:0] K_ALT     = 7'h38;
	localparam logic [6:0] K_CAPS    = 7'h3A;
	localparam logic [6:0] K_NUM     = 7'h45;
	localparam logic [6:0] K_SCROLL  = 7'h46;

	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

	localparam logic [6:0] ROM_PLAIN [ROM_DEPTH] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] ROM_SHIFT [ROM_DEPTH] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// Codes past the table read as no character.
	function automatic logic [6:0] rom_char(input logic [6:0] code, input logic shifted);
		logic [6:0] ch;
		ch = 7'h00;
		if (code <= MAX_CODE) begin
			ch = shifted ? ROM_SHIFT[code] : ROM_PLAIN[code];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ps2_scancode_to_ascii.sv]
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_stall    scan_byte
// out      source     out_valid/out_stall  char_valid, char_code, code_dropped, led_update,
//                                          led_pattern, shift_held, ctrl_held, alt_held
//
// One byte per cycle unless out_stall holds a pending result; an accepted byte passes the input
// register, then the table lookup and key-state update into the result register.
// Reset clears all key, lock and prefix state; no result is pending after reset.
// A stalled result holds; the input register still fills behind it, and in_stall
// rises only when both registers are full and the result is not taken.

module ps2_scancode_to_ascii import ps2sc_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] scan_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       char_valid,
	output logic [6:0] char_code,
	output logic       code_dropped,
	output logic       led_update,
	output logic [2:0] led_pattern,
	output logic       shift_held,
	output logic       ctrl_held,
	output logic       alt_held
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;

	logic       ext_q;
	logic       caps_q, num_q, scroll_q;
	logic       lshift_q, rshift_q;
	logic [1:0] ctrl_q, alt_q;

	logic       out_advance, step;
	logic [6:0] code;
	logic       is_prefix, dropped, press, key_event;
	logic       caps_d, num_d, scroll_d, lshift_d, rshift_d;
	logic [1:0] ctrl_d, alt_d;
	logic       led_d, shift_d, sh, ext_col;
	logic [6:0] plain, ch;

	assign out_advance = !out_valid_q || !out_stall;
	assign step        = valid_s1 && out_advance;
	assign in_stall    = valid_s1 && !out_advance;
	assign out_valid   = out_valid_q;

	always_comb begin
		code        = byte_s1[6:0];
		is_prefix   = (byte_s1 == PREFIX_BYTE);
		dropped     = !is_prefix && (code > MAX_CODE);
		key_event   = !is_prefix && !dropped;
		press       = key_event && !byte_s1[7];

		ctrl_d   = ctrl_q;
		alt_d    = alt_q;
		lshift_d = lshift_q;
		rshift_d = rshift_q;
		if (key_event) begin
			if (code == K_CTRL) begin
				ctrl_d[ext_q] = press;
			end else if (code == K_ALT) begin
				alt_d[ext_q] = press;
			end else if (!ext_q && code == K_SHIFT_L) begin
				lshift_d = press;
			end else if (!ext_q && code == K_SHIFT_R) begin
				rshift_d = press;
			end
		end

		// Toggle on every press, repeats and extended forms too.
		caps_d   = caps_q ^ (press && code == K_CAPS);
		num_d    = num_q ^ (press && code == K_NUM);
		scroll_d = scroll_q ^ (press && code == K_SCROLL);
		led_d    = press && (code == K_CAPS || code == K_NUM || code == K_SCROLL);

		shift_d = lshift_d || rshift_d;
		plain   = rom_char(code, 1'b0);
		sh      = shift_d;
		if (plain >= CHAR_LOWER_A && plain <= CHAR_LOWER_Z) begin
			sh = shift_d ^ caps_d;
		end
		ext_col = ext_q && (code != K_SLASH);
		ch      = press ? rom_char(code, sh || ext_col) : 7'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ext_q       <= 1'b0;
			caps_q      <= 1'b0;
			num_q       <= 1'b0;
			scroll_q    <= 1'b0;
			lshift_q    <= 1'b0;
			rshift_q    <= 1'b0;
			ctrl_q      <= 2'b00;
			alt_q       <= 2'b00;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_advance) begin
				out_valid_q <= valid_s1;
			end
			if (step) begin
				ext_q    <= is_prefix;
				caps_q   <= caps_d;
				num_q    <= num_d;
				scroll_q <= scroll_d;
				lshift_q <= lshift_d;
				rshift_q <= rshift_d;
				ctrl_q   <= ctrl_d;
				alt_q    <= alt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= scan_byte;
		end
		if (step) begin
			char_valid   <= (ch != 7'h00);
			char_code    <= ch;
			code_dropped <= dropped;
			led_update   <= led_d;
			led_pattern  <= {caps_d, num_d, scroll_d};
			shift_held   <= shift_d;
			ctrl_held    <= |ctrl_d;
			alt_held     <= |alt_d;
		end
	end

endmodule

`default_nettype wire

[tb/sv/ps2_scancode_to_ascii_tb.sv]
`default_nettype none

module ps2_scancode_to_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2sc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] REL_BIT = 8'h80;

	localparam logic [6:0] PLAIN_COL [96] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
		7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
		7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] SHIFT_COL [96] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		logic       code_dropped;
		logic       led_update;
		logic [2:0] led_pattern;
		logic       shift_held;
		logic       ctrl_held;
		logic       alt_held;
	} key_result_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	class keymap_tracker;
		bit ext_seen;
		bit caps_on;
		bit num_on;
		bit scroll_on;
		bit lshift;
		bit rshift;
		bit [1:0] ctrl_bits;
		bit [1:0] alt_bits;
		key_result_t awaited[$];
		int errors;

		function int count();
			return awaited.size();
		endfunction

		function void hold_key(logic [6:0] code, bit ext, bit down);
			int slot;
			slot = ext ? 1 : 0;
			if (code == K_CTRL) begin
				ctrl_bits[slot] = down;
			end else if (code == K_ALT) begin
				alt_bits[slot] = down;
			end else if (!ext && code == K_SHIFT_L) begin
				lshift = down;
			end else if (!ext && code == K_SHIFT_R) begin
				rshift = down;
			end
		endfunction

		function void note_scan(logic [7:0] b);
			key_result_t r;
			bit ext;
			bit sh;
			logic [6:0] code;
			logic [6:0] plain;
			logic [6:0] ch;
			r = '0;
			ch = 7'h00;
			if (b == PREFIX_BYTE) begin
				ext_seen = 1'b1;
			end else begin
				ext = ext_seen;
				code = b[6:0];
				ext_seen = 1'b0;
				if (code > MAX_CODE) begin
					r.code_dropped = 1'b1;
				end else if ((b & REL_BIT) != 0) begin
					hold_key(code, ext, 1'b0);
				end else begin
					hold_key(code, ext, 1'b1);
					if (code == K_NUM) begin
						num_on = !num_on;
						r.led_update = 1'b1;
					end else if (code == K_CAPS) begin
						caps_on = !caps_on;
						r.led_update = 1'b1;
					end else if (code == K_SCROLL) begin
						scroll_on = !scroll_on;
						r.led_update = 1'b1;
					end
					sh = lshift | rshift;
					plain = PLAIN_COL[code];
					if (plain >= CHAR_LOWER_A && plain <= CHAR_LOWER_Z)
						sh = sh ^ caps_on;
					// extended keys other than keypad slash read the shifted column
					if (ext && code != K_SLASH)
						ch = SHIFT_COL[code];
					else
						ch = sh ? SHIFT_COL[code] : plain;
				end
			end
			r.char_valid = (ch != 7'h00);
			r.char_code = ch;
			r.led_pattern = {caps_on, num_on, scroll_on};
			r.shift_held = lshift | rshift;
			r.ctrl_held = |ctrl_bits;
			r.alt_held = |alt_bits;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_beat(key_result_t got);
			key_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			compare_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
			compare_field("char_code", 8'(want.char_code), 8'(got.char_code));
			compare_field("code_dropped", 8'(want.code_dropped), 8'(got.code_dropped));
			compare_field("led_update", 8'(want.led_update), 8'(got.led_update));
			compare_field("led_pattern", 8'(want.led_pattern), 8'(got.led_pattern));
			compare_field("shift_held", 8'(want.shift_held), 8'(got.shift_held));
			compare_field("ctrl_held", 8'(want.ctrl_held), 8'(got.ctrl_held));
			compare_field("alt_held", 8'(want.alt_held), 8'(got.alt_held));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] scan_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       char_valid;
	logic [6:0] char_code;
	logic       code_dropped;
	logic       led_update;
	logic [2:0] led_pattern;
	logic       shift_held;
	logic       ctrl_held;
	logic       alt_held;

	keymap_tracker tracker = new();
	logic [7:0] scan_q[$];
	int cycle_cnt = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	ps2_scancode_to_ascii dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.scan_byte    (scan_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_valid   (char_valid),
		.char_code    (char_code),
		.code_dropped (code_dropped),
		.led_update   (led_update),
		.led_pattern  (led_pattern),
		.shift_held   (shift_held),
		.ctrl_held    (ctrl_held),
		.alt_held     (alt_held)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// check the result first: a beat leaving now belongs to an older byte
	always @(posedge clk) begin : watch
		key_result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.char_valid = char_valid;
				got.char_code = char_code;
				got.code_dropped = code_dropped;
				got.led_update = led_update;
				got.led_pattern = led_pattern;
				got.shift_held = shift_held;
				got.ctrl_held = ctrl_held;
				got.alt_held = alt_held;
				tracker.check_beat(got);
			end
			if (in_valid && !in_stall)
				tracker.note_scan(scan_byte);
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
			STALL_PERIODIC: out_stall <= (stall_left % 3 == 0);
			default: out_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	function automatic logic [7:0] key_down(logic [6:0] code);
		return {1'b0, code};
	endfunction

	function automatic logic [7:0] key_up(logic [6:0] code);
		return {1'b1, code};
	endfunction

	task automatic send_beat(input logic [7:0] b);
		@(negedge clk);
		in_valid <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause_in(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// drain the byte queue in bursts, sometimes back to back
	task automatic play_queue();
		int burst;
		while (scan_q.size() > 0) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && scan_q.size() > 0) begin
				send_beat(scan_q.pop_front());
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				pause_in($urandom_range(1, 6));
		end
		pause_in(1);
	endtask

	task automatic wait_results();
		while (tracker.count() != 0) @(posedge clk);
	endtask

	task automatic add_stroke();
		logic [6:0] mods [4];
		logic [6:0] locks [3];
		logic [6:0] code;
		bit ext;
		int pick;
		mods = '{K_CTRL, K_SHIFT_L, K_SHIFT_R, K_ALT};
		locks = '{K_CAPS, K_NUM, K_SCROLL};
		pick = $urandom_range(0, 99);
		ext = ($urandom_range(0, 99) < 25);
		if (pick < 12) begin
			scan_q.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 27) begin
			code = mods[$urandom_range(0, 3)];
			if (ext)
				scan_q.push_back(PREFIX_BYTE);
			scan_q.push_back($urandom_range(0, 1) ? key_up(code) : key_down(code));
		end else if (pick < 35) begin
			code = locks[$urandom_range(0, 2)];
			repeat ($urandom_range(1, 3)) begin
				if (ext)
					scan_q.push_back(PREFIX_BYTE);
				scan_q.push_back(key_down(code));
			end
			scan_q.push_back(key_up(code));
		end else if (pick < 40) begin
			code = 7'($urandom_range(MAX_CODE + 1, 127));
			if (ext)
				scan_q.push_back(PREFIX_BYTE);
			scan_q.push_back({1'($urandom_range(0, 1)), code});
		end else begin
			code = 7'($urandom_range(0, MAX_CODE));
			repeat ($urandom_range(1, 3)) begin
				if (ext)
					scan_q.push_back(PREFIX_BYTE);
				scan_q.push_back(key_down(code));
			end
			if ($urandom_range(0, 99) < 80) begin
				if (ext)
					scan_q.push_back(PREFIX_BYTE);
				scan_q.push_back(key_up(code));
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		scan_q = '{8'h00, 8'hFF, key_down(7'h1E), key_down(K_CAPS), key_down(7'h1E),
			key_up(K_CAPS), key_down(K_SHIFT_L), key_down(7'h1E), key_down(7'h02),
			key_up(K_SHIFT_L), key_down(K_CAPS), PREFIX_BYTE, PREFIX_BYTE,
			key_down(K_SLASH), PREFIX_BYTE, key_down(K_SHIFT_R), key_down(K_CTRL),
			PREFIX_BYTE, key_down(K_CTRL), key_up(K_CTRL), PREFIX_BYTE, key_down(K_ALT),
			key_down(K_NUM), key_down(K_NUM), PREFIX_BYTE, key_down(K_SCROLL),
			PREFIX_BYTE, 8'h60, PREFIX_BYTE, key_down(7'h53), key_down(MAX_CODE)};
		play_queue();
		wait_results();

		// hold the sender after each chunk until every result is back
		repeat (5) begin
			while (scan_q.size() < 260)
				add_stroke();
			play_queue();
			wait_results();
		end

		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
